FILE: hw/rtl/scpt_pkg.sv
// shared types and constants for the segment check and page translate block
package scpt_pkg;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SEG_MISS  = 3'd1;
  localparam logic [2:0] ST_PAGE_MISS = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_WRITTEN   = 3'd4;

  // item modes
  localparam logic [1:0] MODE_XLATE  = 2'd0;
  localparam logic [1:0] MODE_SEG    = 2'd1;
  localparam logic [1:0] MODE_PAGE   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PAGE_SIZE = 2'd0;
  localparam logic [1:0] REG_SEG_COUNT = 2'd1;
  localparam logic [1:0] REG_PAGE_COUNT = 2'd2;

  // field widths
  localparam int FIELD_AW = 24;
  localparam int PS_W     = 13;
  localparam int FRAME_W  = 12;
  localparam logic [PS_W-1:0] PS_MAX = 13'd4096;

endpackage

FILE: hw/rtl/segment_check_page_translate_core.sv
// segment check and paged address translation top level
//
// channel | dir | signals                      | contents
// s_*     | in  | s_tvalid s_tready s_tdata     | tdata: address, entry_index, base_value,
//         |     | s_tuser                      |   limit_value, frame_value; tuser: mode
// m_*     | out | m_tvalid m_tready m_tdata     | tdata: physical_address; tuser: status
// cfg_*   | in  | cfg_we cfg_index cfg_data     | page_size, segment_count, page_count
//
// one item at a time. a table write goes straight to its result. a translate scans
// the segments in use (k segments scanned, one sync memory read each), runs a
// FIELD_AW-wide restoring divide (one quotient bit per step), then reads the page
// table, multiplies and adds. reset is synchronous and clears control state only;
// the tables hold nothing defined until written. a stalled result sits in the
// output register while the next item is accepted.
module segment_check_page_translate_core
  import scpt_pkg::*;
#(
  parameter int MAX_SEGMENTS = 8,
  parameter int MAX_PAGES    = 256,
  parameter int ADDR_WIDTH   = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [23:0] address, [31:24] entry_index, [55:32] base_value,
  // [79:56] limit_value, [91:80] frame_value, [95:92] zero
  input  logic [95:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [23:0] physical_address
  output logic [23:0] m_tdata,
  // [2:0] status
  output logic [2:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int SW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int PW  = $clog2(MAX_PAGES);
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam logic [FIELD_AW-1:0] AMASK = (ADDR_WIDTH >= FIELD_AW) ? {FIELD_AW{1'b1}} :
    FIELD_AW'((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam logic [32:0] ALIMIT = 33'd1 << ADDR_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SCMP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PRD  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // configuration registers
  logic [12:0] page_size;
  logic [3:0]  segment_count;
  logic [8:0]  page_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size     <= 13'd256;
      segment_count <= 4'd0;
      page_count    <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAGE_SIZE:  page_size     <= cfg_data;
        REG_SEG_COUNT:  segment_count <= cfg_data[3:0];
        REG_PAGE_COUNT: page_count    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // effective page size and counts
  logic [PS_W-1:0] ps;
  logic [CW-1:0]   seg_n;
  logic [PCW-1:0]  pg_n;

  always_comb begin
    if (page_size == '0) ps = 13'd1;
    else if (page_size > PS_MAX) ps = PS_MAX;
    else ps = page_size;
    if (32'(segment_count) > MAX_SEGMENTS) seg_n = CW'(MAX_SEGMENTS);
    else seg_n = CW'(segment_count);
    if (32'(page_count) > MAX_PAGES) pg_n = PCW'(MAX_PAGES);
    else pg_n = PCW'(page_count);
  end

  // input field split
  logic [FIELD_AW-1:0] in_addr, in_base, in_limit;
  logic [7:0]          in_idx;
  logic [FRAME_W-1:0]  in_frame;
  assign in_addr  = s_tdata[23:0] & AMASK;
  assign in_idx   = s_tdata[31:24];
  assign in_base  = s_tdata[55:32];
  assign in_limit = s_tdata[79:56];
  assign in_frame = s_tdata[91:80];

  logic [2:0] state;
  logic       accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // segment table: base and length side by side
  logic [2*FIELD_AW-1:0] seg_mem [MAX_SEGMENTS];
  logic [2*FIELD_AW-1:0] seg_q;
  logic [CW-1:0]         seg_idx;

  always_ff @(posedge clk) begin
    if (accept && s_tuser == MODE_SEG && 32'(in_idx) < MAX_SEGMENTS) begin
      seg_mem[in_idx[SW-1:0]] <= {in_limit, in_base};
    end
    seg_q <= seg_mem[seg_idx[SW-1:0]];
  end

  // page table
  logic [FRAME_W-1:0]  pg_mem [MAX_PAGES];
  logic [FRAME_W-1:0]  pg_q;
  logic [FIELD_AW-1:0] div_quo;

  always_ff @(posedge clk) begin
    if (accept && s_tuser == MODE_PAGE && 32'(in_idx) < MAX_PAGES) begin
      pg_mem[PW'(in_idx)] <= in_frame;
    end
    pg_q <= pg_mem[div_quo[PW-1:0]];
  end

  // segment compare, sum taken one bit wider
  logic [FIELD_AW-1:0] addr;
  logic [FIELD_AW:0]   seg_end;
  logic                seg_hit;
  assign seg_end = {1'b0, seg_q[FIELD_AW-1:0]} + {1'b0, seg_q[2*FIELD_AW-1:FIELD_AW]};
  assign seg_hit = (addr >= seg_q[FIELD_AW-1:0]) && ({1'b0, addr} < seg_end);

  // restoring divide step
  logic [PS_W-1:0] div_rem;
  logic [PS_W:0]   div_trial;
  logic            div_bit;
  logic [4:0]      div_cnt;
  assign div_trial = {div_rem, div_quo[FIELD_AW-1]};
  assign div_bit   = (div_trial >= {1'b0, ps});

  // final address arithmetic
  logic [FRAME_W+PS_W-1:0] prod;
  logic [32:0]             sum;
  assign sum = 33'(prod) + 33'(div_rem);

  logic [2:0]          res_status;
  logic [FIELD_AW-1:0] res_phys;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seg_idx <= '0;
      div_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr       <= in_addr;
            res_phys   <= '0;
            seg_idx    <= '0;
            res_status <= ST_WRITTEN;
            if (s_tuser == MODE_XLATE) begin
              if (seg_n == '0) begin
                res_status <= ST_SEG_MISS;
                state <= S_DONE;
              end else begin
                state <= S_SRD;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (seg_hit) begin
            div_rem <= '0;
            div_quo <= addr;
            div_cnt <= '0;
            state   <= S_DIV;
          end else if (seg_idx + CW'(1) == seg_n) begin
            res_status <= ST_SEG_MISS;
            state <= S_DONE;
          end else begin
            seg_idx <= seg_idx + CW'(1);
            state <= S_SRD;
          end
        end
        S_DIV: begin
          div_quo <= {div_quo[FIELD_AW-2:0], div_bit};
          div_rem <= div_bit ? PS_W'(div_trial - {1'b0, ps}) : div_trial[PS_W-1:0];
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(FIELD_AW - 1)) state <= S_PRD;
        end
        S_PRD: begin
          if (div_quo >= FIELD_AW'(pg_n)) begin
            res_status <= ST_PAGE_MISS;
            state <= S_DONE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= pg_q * ps;
          state <= S_ADD;
        end
        S_ADD: begin
          if (sum >= ALIMIT) begin
            res_status <= ST_OVERFLOW;
          end else begin
            res_status <= ST_OK;
            res_phys   <= sum[FIELD_AW-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= res_phys;
      m_tuser  <= res_status;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // a non-translated result never carries an address
  a_zero_phys: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("address on failed result");

  // segment scan never runs past the entries in use
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCMP) |-> (seg_idx < seg_n))
    else $error("segment scan out of range");

  // a finished divide always hands over to the page read
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == 5'(FIELD_AW - 1)) |=> (state == S_PRD))
    else $error("divide did not finish");

endmodule
